[rtl/bole_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_pkg
// Shared types and constants for the bounded ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

    localparam int DEPTH = 16;
    localparam int WIDTH = 32;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        ACT_PUSH_BACK  = 4'd0,
        ACT_POP_BACK   = 4'd1,
        ACT_PUSH_FRONT = 4'd2,
        ACT_POP_FRONT  = 4'd3,
        ACT_INSERT     = 4'd4,
        ACT_ERASE      = 4'd5,
        ACT_FIND       = 4'd6,
        ACT_SET        = 4'd7,
        ACT_SORT       = 4'd8,
        ACT_BSEARCH    = 4'd9,
        ACT_REMOVE_ALL = 4'd10,
        ACT_DUMP       = 4'd11
    } action_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_BAD_POS   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_WRITE,
        S_FIND,
        S_SORT_OUTER,
        S_SORT_INNER,
        S_SORT_PLACE,
        S_BS_STEP,
        S_REMOVE,
        S_DUMP,
        S_RESULT
    } state_t;

    // datapath register file ops, one per cycle
    typedef enum logic [1:0] {
        RF_NONE,
        RF_WRITE_VAL,  // wr_addr <= operand
        RF_WRITE_TMP,  // wr_addr <= tmp
        RF_MOVE        // wr_addr <= elem[rd_addr]
    } rf_op_t;

    typedef struct packed {
        rf_op_t         op;
        logic [AW-1:0]  rd_addr;
        logic [AW-1:0]  wr_addr;
        logic           load_tmp;   // tmp <= elem[rd_addr]
    } dp_cmd_t;

    typedef struct packed {
        logic           rd_eq_val;  // elem[rd_addr] == operand
        logic           rd_gt_tmp;  // elem[rd_addr] > tmp (signed)
        logic           rd_gt_val;  // elem[rd_addr] > operand
        logic [WIDTH-1:0] rd_data;
    } dp_stat_t;

endpackage

[rtl/bole_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_datapath
// Element store, temporary register and comparators.
// ----------------------------------------------------------------------------
module bole_datapath (
    input  logic                      aclk,
    input  bole_pkg::dp_cmd_t         cmd,
    input  logic [bole_pkg::WIDTH-1:0] val,
    output bole_pkg::dp_stat_t        stat
);

    logic [bole_pkg::WIDTH-1:0] elem_reg [bole_pkg::DEPTH];
    logic [bole_pkg::WIDTH-1:0] tmp_reg;
    logic [bole_pkg::WIDTH-1:0] rd;

    assign rd = elem_reg[cmd.rd_addr];

    always_ff @(posedge aclk) begin
        case (cmd.op)
            bole_pkg::RF_WRITE_VAL: elem_reg[cmd.wr_addr] <= val;
            bole_pkg::RF_WRITE_TMP: elem_reg[cmd.wr_addr] <= tmp_reg;
            bole_pkg::RF_MOVE:      elem_reg[cmd.wr_addr] <= rd;
            default: ;
        endcase
        if (cmd.load_tmp) begin
            tmp_reg <= rd;
        end
    end

    assign stat.rd_eq_val = (rd == val);
    assign stat.rd_gt_tmp = ($signed(rd) > $signed(tmp_reg));
    assign stat.rd_gt_val = ($signed(rd) > $signed(val));
    assign stat.rd_data   = rd;

endmodule

[rtl/bole_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_ctrl
// Sequencer: decodes the action, walks the list and builds results.
// ----------------------------------------------------------------------------
module bole_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [3:0]                s_action,
    input  logic [4:0]                s_position,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_status,
    output logic [4:0]                m_found_index,
    output logic [31:0]               m_element,
    output logic [4:0]                m_length,
    output logic                      m_last,
    output bole_pkg::dp_cmd_t         cmd,
    input  bole_pkg::dp_stat_t        stat
);

    localparam int AW = bole_pkg::AW;
    localparam int CW = bole_pkg::CW;
    localparam logic [CW-1:0] FULL = CW'(bole_pkg::DEPTH);

    bole_pkg::state_t state_reg, state_next;
    logic [3:0]    act_reg, act_next;
    logic [4:0]    pos_reg, pos_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    // general index registers: i = loop index / lo, j = inner / hi, w = write ptr
    logic [CW:0]   i_reg, i_next, j_reg, j_next, w_reg, w_next;
    logic [2:0]    st_reg, st_next;
    logic [4:0]    idx_reg, idx_next;
    logic [31:0]   el_reg, el_next;
    logic          last_reg, last_next;
    logic          mv_reg, mv_next;
    logic [CW:0]   mid;

    assign mid = i_reg + ((j_reg - i_reg) >> 1);
    // a pending result must leave before the result register is reloaded
    assign s_ready = (state_reg == bole_pkg::S_IDLE) && (!mv_reg || m_ready);
    assign m_valid = mv_reg;
    assign m_status = st_reg;
    assign m_found_index = idx_reg;
    assign m_element = el_reg;
    assign m_length = 5'(cnt_reg);
    assign m_last = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bole_pkg::S_IDLE;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
        act_reg  <= act_next;
        pos_reg  <= pos_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        w_reg    <= w_next;
        st_reg   <= st_next;
        idx_reg  <= idx_next;
        el_reg   <= el_next;
        last_reg <= last_next;
    end

    always_comb begin
        state_next = state_reg;
        act_next = act_reg;
        pos_next = pos_reg;
        cnt_next = cnt_reg;
        i_next = i_reg;
        j_next = j_reg;
        w_next = w_reg;
        st_next = st_reg;
        idx_next = idx_reg;
        el_next = el_reg;
        last_next = last_reg;
        mv_next = mv_reg;
        cmd = '{op: bole_pkg::RF_NONE, rd_addr: '0, wr_addr: '0, load_tmp: 1'b0};
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            bole_pkg::S_IDLE: begin
                if (s_valid && s_ready) begin
                    act_next = s_action;
                    pos_next = s_position;
                    st_next = bole_pkg::ST_OK;
                    idx_next = 5'h1f;
                    el_next = '0;
                    last_next = 1'b1;
                    state_next = bole_pkg::S_DECODE;
                end
            end
            bole_pkg::S_DECODE: begin
                state_next = bole_pkg::S_RESULT;
                case (act_reg)
                    bole_pkg::ACT_PUSH_BACK: begin
                        if (cnt_reg == FULL) st_next = bole_pkg::ST_FULL;
                        else begin
                            cmd.op = bole_pkg::RF_WRITE_VAL;
                            cmd.wr_addr = AW'(cnt_reg);
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    bole_pkg::ACT_POP_BACK: begin
                        if (cnt_reg == 0) st_next = bole_pkg::ST_EMPTY;
                        else cnt_next = cnt_reg - 1'b1;
                    end
                    bole_pkg::ACT_PUSH_FRONT, bole_pkg::ACT_INSERT: begin
                        if (cnt_reg == FULL) st_next = bole_pkg::ST_FULL;
                        else if (act_reg == bole_pkg::ACT_INSERT &&
                                 (pos_reg == 0 || (CW+1)'(pos_reg) > (CW+1)'(cnt_reg)))
                            st_next = bole_pkg::ST_BAD_POS;
                        else begin
                            i_next = (CW+1)'(cnt_reg);
                            j_next = (act_reg == bole_pkg::ACT_INSERT) ?
                                     (CW+1)'(pos_reg - 5'd1) : '0;
                            state_next = bole_pkg::S_SHIFT_UP;
                        end
                    end
                    bole_pkg::ACT_POP_FRONT, bole_pkg::ACT_ERASE: begin
                        if (cnt_reg == 0) st_next = bole_pkg::ST_EMPTY;
                        else if (act_reg == bole_pkg::ACT_ERASE &&
                                 (pos_reg == 0 || (CW+1)'(pos_reg) > (CW+1)'(cnt_reg)))
                            st_next = bole_pkg::ST_BAD_POS;
                        else begin
                            i_next = (act_reg == bole_pkg::ACT_ERASE) ?
                                     (CW+1)'(pos_reg - 5'd1) : '0;
                            state_next = bole_pkg::S_SHIFT_DN;
                        end
                    end
                    bole_pkg::ACT_SET: begin
                        if (cnt_reg == 0) st_next = bole_pkg::ST_EMPTY;
                        else if (pos_reg == 0 || (CW+1)'(pos_reg) > (CW+1)'(cnt_reg))
                            st_next = bole_pkg::ST_BAD_POS;
                        else begin
                            cmd.op = bole_pkg::RF_WRITE_VAL;
                            cmd.wr_addr = AW'(pos_reg - 5'd1);
                        end
                    end
                    bole_pkg::ACT_FIND: begin
                        if (cnt_reg == 0) st_next = bole_pkg::ST_EMPTY;
                        else begin
                            st_next = bole_pkg::ST_NOT_FOUND;
                            i_next = '0;
                            state_next = bole_pkg::S_FIND;
                        end
                    end
                    bole_pkg::ACT_SORT, bole_pkg::ACT_BSEARCH: begin
                        if (act_reg == bole_pkg::ACT_BSEARCH && cnt_reg == 0)
                            st_next = bole_pkg::ST_EMPTY;
                        else begin
                            i_next = (CW+1)'(1);
                            state_next = bole_pkg::S_SORT_OUTER;
                        end
                    end
                    bole_pkg::ACT_REMOVE_ALL: begin
                        i_next = '0;
                        w_next = '0;
                        state_next = bole_pkg::S_REMOVE;
                    end
                    bole_pkg::ACT_DUMP: begin
                        if (cnt_reg == 0) st_next = bole_pkg::ST_EMPTY;
                        else begin
                            i_next = '0;
                            state_next = bole_pkg::S_DUMP;
                        end
                    end
                    default: ;
                endcase
            end
            bole_pkg::S_SHIFT_UP: begin
                // elem[i] <= elem[i-1] down to j, then elem[j] <= value
                if (i_reg == j_reg) begin
                    cmd.op = bole_pkg::RF_WRITE_VAL;
                    cmd.wr_addr = AW'(j_reg);
                    cnt_next = cnt_reg + 1'b1;
                    state_next = bole_pkg::S_RESULT;
                end else begin
                    cmd.op = bole_pkg::RF_MOVE;
                    cmd.rd_addr = AW'(i_reg - 1'b1);
                    cmd.wr_addr = AW'(i_reg);
                    i_next = i_reg - 1'b1;
                end
            end
            bole_pkg::S_SHIFT_DN: begin
                if (i_reg + 1'b1 >= (CW+1)'(cnt_reg)) begin
                    cnt_next = cnt_reg - 1'b1;
                    state_next = bole_pkg::S_RESULT;
                end else begin
                    cmd.op = bole_pkg::RF_MOVE;
                    cmd.rd_addr = AW'(i_reg + 1'b1);
                    cmd.wr_addr = AW'(i_reg);
                    i_next = i_reg + 1'b1;
                end
            end
            bole_pkg::S_FIND: begin
                cmd.rd_addr = AW'(i_reg);
                if (stat.rd_eq_val) begin
                    st_next = bole_pkg::ST_OK;
                    idx_next = 5'(i_reg);
                    state_next = bole_pkg::S_RESULT;
                end else if (i_reg + 1'b1 >= (CW+1)'(cnt_reg)) begin
                    state_next = bole_pkg::S_RESULT;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            bole_pkg::S_SORT_OUTER: begin
                // insertion sort: tmp <= elem[i], j <= i
                if (i_reg >= (CW+1)'(cnt_reg)) begin
                    if (act_reg == bole_pkg::ACT_BSEARCH) begin
                        st_next = bole_pkg::ST_NOT_FOUND;
                        i_next = '0;
                        j_next = (CW+1)'(cnt_reg) - 1'b1;
                        state_next = bole_pkg::S_BS_STEP;
                    end else begin
                        state_next = bole_pkg::S_RESULT;
                    end
                end else begin
                    cmd.rd_addr = AW'(i_reg);
                    cmd.load_tmp = 1'b1;
                    j_next = i_reg;
                    state_next = bole_pkg::S_SORT_INNER;
                end
            end
            bole_pkg::S_SORT_INNER: begin
                cmd.rd_addr = AW'(j_reg - 1'b1);
                if (j_reg != 0 && stat.rd_gt_tmp) begin
                    cmd.op = bole_pkg::RF_MOVE;
                    cmd.wr_addr = AW'(j_reg);
                    j_next = j_reg - 1'b1;
                end else begin
                    state_next = bole_pkg::S_SORT_PLACE;
                end
            end
            bole_pkg::S_SORT_PLACE: begin
                cmd.op = bole_pkg::RF_WRITE_TMP;
                cmd.wr_addr = AW'(j_reg);
                i_next = i_reg + 1'b1;
                state_next = bole_pkg::S_SORT_OUTER;
            end
            bole_pkg::S_BS_STEP: begin
                // i = lo, j = hi; hi may go to -1 (all ones), treated as signed
                cmd.rd_addr = AW'(mid);
                if ($signed(i_reg) > $signed(j_reg)) begin
                    state_next = bole_pkg::S_RESULT;
                end else if (stat.rd_eq_val) begin
                    st_next = bole_pkg::ST_OK;
                    idx_next = 5'(mid);
                    state_next = bole_pkg::S_RESULT;
                end else if (stat.rd_gt_val) begin
                    j_next = mid - 1'b1;
                end else begin
                    i_next = mid + 1'b1;
                end
            end
            bole_pkg::S_REMOVE: begin
                if (i_reg >= (CW+1)'(cnt_reg)) begin
                    cnt_next = CW'(w_reg);
                    state_next = bole_pkg::S_RESULT;
                end else begin
                    cmd.rd_addr = AW'(i_reg);
                    if (!stat.rd_eq_val) begin
                        cmd.op = bole_pkg::RF_MOVE;
                        cmd.wr_addr = AW'(w_reg);
                        w_next = w_reg + 1'b1;
                    end
                    i_next = i_reg + 1'b1;
                end
            end
            bole_pkg::S_DUMP: begin
                cmd.rd_addr = AW'(i_reg);
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    st_next = bole_pkg::ST_OK;
                    idx_next = 5'h1f;
                    el_next = 32'(stat.rd_data);
                    last_next = (i_reg + 1'b1 == (CW+1)'(cnt_reg));
                    i_next = i_reg + 1'b1;
                    if (i_reg + 1'b1 == (CW+1)'(cnt_reg)) state_next = bole_pkg::S_IDLE;
                end
            end
            bole_pkg::S_RESULT: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    state_next = bole_pkg::S_IDLE;
                end
            end
            default: state_next = bole_pkg::S_IDLE;
        endcase
    end

endmodule

[rtl/bounded_ordered_list_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_core
// Fixed-capacity signed list with push, pop, insert, search, sort and dump.
// ----------------------------------------------------------------------------
// channel  dir  signals
// s_       in   s_valid s_ready s_action s_position s_operand
// m_       out  m_valid m_ready m_status m_found_index m_element m_length m_last
//
// One transaction at a time. Simple ops pass only through the decode and
// result states; shifts, find, remove and dump walk the element store one
// entry per cycle (dump only while m_ready does not stall); sort is
// insertion sort, and bsearch sorts first, then probes by binary search.
// Reset clears the fill count, the sequencer state and m_valid only.
// A stalled m_ready holds the result register; input waits meanwhile.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_action,
    input  logic [4:0]  s_position,
    input  logic signed [31:0] s_operand,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic signed [4:0]  m_found_index,
    output logic signed [31:0] m_element,
    output logic [4:0]  m_length,
    output logic        m_last
);

    bole_pkg::dp_cmd_t  cmd;
    bole_pkg::dp_stat_t stat;
    logic [31:0] op_reg;
    logic [31:0] el;
    logic [4:0]  fi;

    // operand captured on acceptance
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) op_reg <= s_operand;
    end

    bole_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_index (fi),
        .m_element     (el),
        .m_length      (m_length),
        .m_last        (m_last),
        .cmd           (cmd),
        .stat          (stat)
    );

    bole_datapath u_dp (
        .aclk (aclk),
        .cmd  (cmd),
        .val  (op_reg),
        .stat (stat)
    );

    assign m_element = $signed(el);
    assign m_found_index = $signed(fi);

endmodule
